@@ rtl/swcd_pkg.sv @@
package swcd_pkg;

  localparam int TIME_W = 23;
  localparam int AMT_W  = 24;
  localparam int CMD_W  = 3;
  localparam int MIN_W  = 7;
  localparam int SEC_W  = 6;
  localparam int MS_W   = 10;
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Signed working width for time +/- amount.
  localparam int SUM_W = 26;

  localparam logic [TIME_W-1:0] MAX_MS = TIME_W'(5999999);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd5;

  // Run modes.
  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENDED = 2'd2;

  // Register word index (paddr[2]).
  localparam logic REG_START_IDX = 1'b0;
  localparam logic REG_LIMIT_IDX = 1'b1;

  // Constant division by reciprocal multiply.
  // t / 1000 = (t * ceil(2^33 / 1000)) >> 33, exact for t < 2^23.
  localparam int Q_W = 14;
  localparam logic [23:0] RECIP_1000 = 24'd8589935;
  localparam int RECIP_1000_SHIFT = 33;
  localparam int PROD1_W = TIME_W + 24;
  // q / 60 = (q * ceil(2^22 / 60)) >> 22, exact for q < 2^14.
  localparam logic [16:0] RECIP_60 = 17'd69906;
  localparam int RECIP_60_SHIFT = 22;
  localparam int PROD2_W = Q_W + 17;
  localparam int MINQ_W = 8;

  typedef struct packed {
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [MODE_W-1:0] mode;
    logic              hold;
  } snap_t;

  function automatic logic [TIME_W-1:0] clamp_ms(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_x;
    max_x = $signed(SUM_W'(MAX_MS));
    if (v < 0) begin
      return '0;
    end else if (v > max_x) begin
      return MAX_MS;
    end else begin
      return v[TIME_W-1:0];
    end
  endfunction

endpackage

@@ rtl/swcd_cmd_if.sv @@
interface swcd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [swcd_pkg::CMD_W-1:0]          command;
  logic signed [swcd_pkg::AMT_W-1:0]   amount_ms;
  logic                                pause_flag;

  modport source (output valid, command, amount_ms, pause_flag, input ready);
  modport sink (input valid, command, amount_ms, pause_flag, output ready);
endinterface

@@ rtl/swcd_res_if.sv @@
interface swcd_res_if;
  logic                          valid;
  logic                          ready;
  logic [swcd_pkg::TIME_W-1:0]   total_ms;
  logic [swcd_pkg::MIN_W-1:0]    minutes;
  logic [swcd_pkg::SEC_W-1:0]    seconds;
  logic [swcd_pkg::MS_W-1:0]     millis;
  logic [swcd_pkg::MODE_W-1:0]   run_state;
  logic                          paused;

  modport source (output valid, total_ms, minutes, seconds, millis, run_state, paused,
                  input ready);
  modport sink (input valid, total_ms, minutes, seconds, millis, run_state, paused,
                output ready);
endinterface

@@ rtl/stopwatch_countdown_timer_unit.sv @@
// Millisecond stopwatch / countdown timer.
// cmd channel: one beat per command (tick, start, end, set pause, add time,
// load) with a signed millisecond amount and a pause flag.
// res channel: one beat per command with the time after that command, as a
// total and split into minutes, seconds and millis, plus run state and pause.
// APB port: word 0 start_time_ms, word 1 limit_ms (nonzero limit selects
// countdown). Write these only while no command is in flight.
// After its command beat is taken, a command passes the input register, state
// update, seconds divide, minute/milli split and result register. Throughput:
// one command per cycle while res is not stalled, set by the single state
// update stage; the split stages are a plain pipeline.
// Reset (rst, synchronous): time 0, idle, not paused, both registers 0,
// pipeline empty.
// When res is stalled the pipeline keeps taking commands until all five
// stages are full; then cmd.ready drops and nothing is lost or repeated.
module stopwatch_countdown_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  swcd_cmd_if.sink                      cmd,
  swcd_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [swcd_pkg::DATA_W-1:0]   pwdata,
  output logic [swcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  swcd_pkg::cfg_t  cfg;
  swcd_pkg::snap_t snap;
  logic            snap_valid;
  logic            snap_ready;

  swcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swcd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  swcd_split u_split (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .res        (res)
  );

endmodule

@@ rtl/swcd_regs.sv @@
module swcd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [swcd_pkg::DATA_W-1:0]   pwdata,
  output logic [swcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output swcd_pkg::cfg_t                cfg
);

  logic [swcd_pkg::TIME_W-1:0] start_ms;
  logic [swcd_pkg::TIME_W-1:0] limit_ms;
  logic                        wr_en;
  logic                        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[swcd_pkg::ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_ms <= '0;
      limit_ms <= '0;
    end else if (wr_en) begin
      unique case (idx)
        swcd_pkg::REG_START_IDX: start_ms <= pwdata[swcd_pkg::TIME_W-1:0];
        swcd_pkg::REG_LIMIT_IDX: limit_ms <= pwdata[swcd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      swcd_pkg::REG_START_IDX:
        prdata = swcd_pkg::DATA_W'(start_ms);
      swcd_pkg::REG_LIMIT_IDX:
        prdata = swcd_pkg::DATA_W'(limit_ms);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.start_ms = start_ms;
  assign cfg.limit_ms = limit_ms;

endmodule

@@ rtl/swcd_core.sv @@
module swcd_core (
  input  logic              clk,
  input  logic              rst,
  swcd_cmd_if.sink          cmd,
  input  swcd_pkg::cfg_t    cfg,
  output swcd_pkg::snap_t   snap,
  output logic              snap_valid,
  input  logic              snap_ready
);

  // input stage
  logic                                v0;
  logic [swcd_pkg::CMD_W-1:0]          op_code;
  logic signed [swcd_pkg::AMT_W-1:0]   amount;
  logic                                pause_req;

  // timer state; doubles as the snapshot stage
  logic                                v1;
  logic [swcd_pkg::TIME_W-1:0]         time_count;
  logic [swcd_pkg::MODE_W-1:0]         run_mode;
  logic                                hold;

  logic [swcd_pkg::TIME_W-1:0]         time_count_next;
  logic [swcd_pkg::MODE_W-1:0]         run_mode_next;
  logic                                hold_next;

  logic                                rdy0;
  logic                                rdy1;
  logic                                adv;

  logic [swcd_pkg::TIME_W-1:0]         lim;
  logic [swcd_pkg::TIME_W-1:0]         start_c;
  logic signed [swcd_pkg::SUM_W-1:0]   time_x;
  logic signed [swcd_pkg::SUM_W-1:0]   amt_x;
  logic signed [swcd_pkg::SUM_W-1:0]   sum;
  logic signed [swcd_pkg::SUM_W-1:0]   diff;

  assign rdy1      = !v1 || snap_ready;
  assign rdy0      = !v0 || rdy1;
  assign adv       = v0 && rdy1;
  assign cmd.ready = rdy0;

  always_ff @(posedge clk) begin
    if (cmd.valid && rdy0) begin
      op_code   <= cmd.command;
      amount    <= cmd.amount_ms;
      pause_req <= cmd.pause_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      time_count <= '0;
      run_mode   <= swcd_pkg::MODE_IDLE;
      hold       <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= cmd.valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (adv) begin
        time_count <= time_count_next;
        run_mode   <= run_mode_next;
        hold       <= hold_next;
      end
    end
  end

  assign lim     = (cfg.limit_ms > swcd_pkg::MAX_MS) ? swcd_pkg::MAX_MS : cfg.limit_ms;
  assign start_c = (cfg.start_ms > swcd_pkg::MAX_MS) ? swcd_pkg::MAX_MS : cfg.start_ms;
  assign time_x  = $signed(swcd_pkg::SUM_W'(time_count));
  assign amt_x   = swcd_pkg::SUM_W'(amount);
  assign sum     = time_x + amt_x;
  assign diff    = time_x - amt_x;

  always_comb begin
    time_count_next = time_count;
    run_mode_next   = run_mode;
    hold_next       = hold;
    unique case (op_code)
      swcd_pkg::CMD_TICK: begin
        if (run_mode == swcd_pkg::MODE_COUNT && !hold) begin
          if (lim == '0) begin
            time_count_next = swcd_pkg::clamp_ms(sum);
          end else if (diff <= 0) begin
            time_count_next = '0;
            run_mode_next   = swcd_pkg::MODE_ENDED;
            hold_next       = 1'b1;
          end else begin
            time_count_next = swcd_pkg::clamp_ms(diff);
          end
        end
      end
      swcd_pkg::CMD_START: begin
        if (run_mode != swcd_pkg::MODE_COUNT) begin
          hold_next     = 1'b0;
          run_mode_next = swcd_pkg::MODE_COUNT;
        end
      end
      swcd_pkg::CMD_END: begin
        if (run_mode == swcd_pkg::MODE_COUNT) begin
          hold_next     = 1'b1;
          run_mode_next = swcd_pkg::MODE_ENDED;
        end
      end
      swcd_pkg::CMD_PAUSE: begin
        hold_next = pause_req;
      end
      swcd_pkg::CMD_ADD: begin
        time_count_next = swcd_pkg::clamp_ms(sum);
      end
      swcd_pkg::CMD_LOAD: begin
        run_mode_next   = swcd_pkg::MODE_IDLE;
        hold_next       = 1'b0;
        time_count_next = (lim != '0) ? lim : start_c;
      end
      default: ;
    endcase
  end

  assign snap.time_ms = time_count;
  assign snap.mode    = run_mode;
  assign snap.hold    = hold;
  assign snap_valid   = v1;

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    time_count <= swcd_pkg::MAX_MS)
    else $error("time_count above limit");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    run_mode != 2'd3)
    else $error("run_mode holds unused code");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(time_count) && $stable(run_mode) && $stable(hold))
    else $error("state changed without a command");

  a_end_pauses: assert property (@(posedge clk) disable iff (rst)
    adv && run_mode == swcd_pkg::MODE_COUNT && run_mode_next == swcd_pkg::MODE_ENDED
    |=> hold && time_count == (($past(op_code) == swcd_pkg::CMD_TICK) ? '0 : $past(time_count)))
    else $error("end of count did not pause");

endmodule

@@ rtl/swcd_split.sv @@
module swcd_split (
  input  logic              clk,
  input  logic              rst,
  input  swcd_pkg::snap_t   snap,
  input  logic              snap_valid,
  output logic              snap_ready,
  swcd_res_if.source        res
);

  logic [swcd_pkg::PROD1_W-1:0]  prod1;
  logic [swcd_pkg::Q_W-1:0]      q_in;
  logic [swcd_pkg::TIME_W-1:0]   rem3;
  logic [swcd_pkg::PROD2_W-1:0]  prod2;
  logic [swcd_pkg::Q_W-1:0]      sec_all;

  // stage 2: whole seconds
  logic                          v2;
  logic [swcd_pkg::TIME_W-1:0]   t2;
  logic [swcd_pkg::Q_W-1:0]      q2;
  logic [swcd_pkg::MODE_W-1:0]   mode2;
  logic                          hold2;

  // stage 3: minutes and millis
  logic                          v3;
  logic [swcd_pkg::TIME_W-1:0]   t3;
  logic [swcd_pkg::Q_W-1:0]      q3;
  logic [swcd_pkg::MINQ_W-1:0]   min3;
  logic [swcd_pkg::MS_W-1:0]     ms3;
  logic [swcd_pkg::MODE_W-1:0]   mode3;
  logic                          hold3;

  // stage 4: result register
  logic                          v4;
  logic [swcd_pkg::TIME_W-1:0]   total;
  logic [swcd_pkg::MIN_W-1:0]    minutes;
  logic [swcd_pkg::SEC_W-1:0]    seconds;
  logic [swcd_pkg::MS_W-1:0]     millis;
  logic [swcd_pkg::MODE_W-1:0]   run_state;
  logic                          paused;

  logic rdy2;
  logic rdy3;
  logic rdy4;

  assign rdy4       = !v4 || res.ready;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign snap_ready = rdy2;

  assign prod1   = swcd_pkg::PROD1_W'(snap.time_ms) * swcd_pkg::PROD1_W'(swcd_pkg::RECIP_1000);
  assign q_in    = prod1[swcd_pkg::RECIP_1000_SHIFT +: swcd_pkg::Q_W];
  assign rem3    = t2 - swcd_pkg::TIME_W'(q2) * swcd_pkg::TIME_W'(1000);
  assign prod2   = swcd_pkg::PROD2_W'(q2) * swcd_pkg::PROD2_W'(swcd_pkg::RECIP_60);
  assign sec_all = q3 - swcd_pkg::Q_W'(min3) * swcd_pkg::Q_W'(60);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy2) begin
        v2 <= snap_valid;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && rdy2) begin
      t2    <= snap.time_ms;
      q2    <= q_in;
      mode2 <= snap.mode;
      hold2 <= snap.hold;
    end
    if (v2 && rdy3) begin
      t3    <= t2;
      q3    <= q2;
      min3  <= prod2[swcd_pkg::RECIP_60_SHIFT +: swcd_pkg::MINQ_W];
      ms3   <= rem3[swcd_pkg::MS_W-1:0];
      mode3 <= mode2;
      hold3 <= hold2;
    end
    if (v3 && rdy4) begin
      total     <= t3;
      minutes   <= min3[swcd_pkg::MIN_W-1:0];
      seconds   <= sec_all[swcd_pkg::SEC_W-1:0];
      millis    <= ms3;
      run_state <= mode3;
      paused    <= hold3;
    end
  end

  assign res.valid     = v4;
  assign res.total_ms  = total;
  assign res.minutes   = minutes;
  assign res.seconds   = seconds;
  assign res.millis    = millis;
  assign res.run_state = run_state;
  assign res.paused    = paused;

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> seconds < 6'd60 && millis < 10'd1000 && minutes < 7'd100)
    else $error("split field out of range");

  a_split_sums: assert property (@(posedge clk) disable iff (rst)
    v4 |-> total == swcd_pkg::TIME_W'(minutes) * swcd_pkg::TIME_W'(60000)
                  + swcd_pkg::TIME_W'(seconds) * swcd_pkg::TIME_W'(1000)
                  + swcd_pkg::TIME_W'(millis))
    else $error("split does not add up to total");

endmodule

@@ sim/swcd_reading_check.sv @@
`timescale 1ns / 100ps
module swcd_reading_check import swcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  swcd_cmd_if               cmd_mon,
  swcd_res_if               res_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                outstanding,
  output int                mismatches
);

  typedef struct packed {
    logic [TIME_W-1:0] total;
    logic [MIN_W-1:0]  mins;
    logic [SEC_W-1:0]  secs;
    logic [MS_W-1:0]   ms;
    logic [MODE_W-1:0] state;
    logic              held;
  } reading_t;

  localparam longint CEIL_MS = longint'(MAX_MS);

  reading_t          readings_due[$];
  logic [TIME_W-1:0] tally_ms;
  logic [MODE_W-1:0] run_mode;
  logic              held;
  logic [TIME_W-1:0] start_cfg;
  logic [TIME_W-1:0] limit_cfg;
  int                fail_count;

  function automatic logic [TIME_W-1:0] pin_ms(input longint v);
    if (v < 0) return '0;
    if (v > CEIL_MS) return MAX_MS;
    return TIME_W'(v);
  endfunction

  // Apply one command beat to the timer state and queue the reading it yields.
  task automatic apply_command(input logic [CMD_W-1:0] op, input longint amt,
                               input logic pf);
    longint   lim;
    longint   diff;
    reading_t r;
    lim = (longint'(limit_cfg) > CEIL_MS) ? CEIL_MS : longint'(limit_cfg);
    case (op)
      CMD_TICK: begin
        if (run_mode == MODE_COUNT && !held) begin
          if (lim == 0) begin
            tally_ms = pin_ms(longint'(tally_ms) + amt);
          end else begin
            diff = longint'(tally_ms) - amt;
            if (diff <= 0) begin
              tally_ms = '0;
              run_mode = MODE_ENDED;
              held = 1'b1;
            end else begin
              tally_ms = pin_ms(diff);
            end
          end
        end
      end
      CMD_START: begin
        if (run_mode != MODE_COUNT) begin
          held = 1'b0;
          run_mode = MODE_COUNT;
        end
      end
      CMD_END: begin
        if (run_mode == MODE_COUNT) begin
          held = 1'b1;
          run_mode = MODE_ENDED;
        end
      end
      CMD_PAUSE: held = pf;
      CMD_ADD:   tally_ms = pin_ms(longint'(tally_ms) + amt);
      CMD_LOAD: begin
        run_mode = MODE_IDLE;
        held = 1'b0;
        tally_ms = (lim > 0) ? TIME_W'(lim) : pin_ms(longint'(start_cfg));
      end
      default: ;
    endcase
    r.total = tally_ms;
    r.mins  = MIN_W'(tally_ms / 60000);
    r.secs  = SEC_W'((tally_ms / 1000) % 60);
    r.ms    = MS_W'(tally_ms % 1000);
    r.state = run_mode;
    r.held  = held;
    readings_due.push_back(r);
  endtask

  function automatic int field_bad(input string name, input longint want,
                                   input longint got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    int       bad;
    if (rst) begin
      readings_due.delete();
      tally_ms   = '0;
      run_mode   = MODE_IDLE;
      held       = 1'b0;
      start_cfg  = '0;
      limit_cfg  = '0;
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LIMIT_IDX) limit_cfg = pwdata[TIME_W-1:0];
        else start_cfg = pwdata[TIME_W-1:0];
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        apply_command(cmd_mon.command, longint'(cmd_mon.amount_ms), cmd_mon.pause_flag);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, total_ms %0d", $time,
                   res_mon.total_ms);
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          bad = 0;
          bad += field_bad("total_ms", want.total, res_mon.total_ms);
          bad += field_bad("minutes", want.mins, res_mon.minutes);
          bad += field_bad("seconds", want.secs, res_mon.seconds);
          bad += field_bad("millis", want.ms, res_mon.millis);
          bad += field_bad("run_state", want.state, res_mon.run_state);
          bad += field_bad("paused", want.held, res_mon.paused);
          if (bad != 0) fail_count++;
        end
      end
    end
    outstanding = readings_due.size();
    mismatches  = fail_count;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import swcd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam logic [AMT_W-1:0] AMT_POS_MAX = 24'h7FFFFF;
  localparam logic [AMT_W-1:0] AMT_NEG_MAX = 24'h800000;
  localparam logic [TIME_W-1:0] REG_ALL_ONES = 23'h7FFFFF;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 187;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                outstanding;
  int                mismatches;
  int                burst_left;
  int                quiet_cycles;
  int                rx_left;
  rx_pattern_t       rx_pattern;

  swcd_cmd_if cmd_bus();
  swcd_res_if res_bus();

  stopwatch_countdown_timer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swcd_reading_check reading_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_mon     (cmd_bus),
    .res_mon     (res_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_pattern)
      RX_OPEN:   res_bus.ready <= 1'b1;
      RX_COIN:   res_bus.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: res_bus.ready <= ($urandom_range(0, 9) != 0);
      default:   res_bus.ready <= ((rx_left % 9) < 2);
    endcase
  end

  // All tasks below start and end at a falling edge.
  task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [AMT_W-1:0] amt,
                          input logic pf);
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= op;
    cmd_bus.amount_ms  <= amt;
    cmd_bus.pause_flag <= pf;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
  endtask

  task automatic issue(input logic [CMD_W-1:0] op, input logic [AMT_W-1:0] amt,
                       input logic pf);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push_cmd(op, amt, pf);
  endtask

  task automatic drain();
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic idx, input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [TIME_W-1:0] start_val,
                              input logic [TIME_W-1:0] limit_val);
    drain();
    apb_write(REG_START_IDX, start_val);
    apb_write(REG_LIMIT_IDX, limit_val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return AMT_W'($urandom_range(0, 3000));
      5:             return AMT_W'($urandom_range(0, 200000));
      6:             return -AMT_W'($urandom_range(0, 3000));
      7, 8:          return AMT_W'($urandom());
      default:       return $urandom_range(0, 1) ? AMT_POS_MAX : AMT_NEG_MAX;
    endcase
  endfunction

  task automatic random_cmd();
    int               roll;
    logic [CMD_W-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 55)      op = CMD_TICK;
    else if (roll < 63) op = CMD_START;
    else if (roll < 68) op = CMD_END;
    else if (roll < 76) op = CMD_PAUSE;
    else if (roll < 86) op = CMD_ADD;
    else if (roll < 95) op = CMD_LOAD;
    else op = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
    issue(op, pick_amount(), 1'($urandom_range(0, 1)));
  endtask

  task automatic phase_regs(input int p);
    case (p)
      0: program_regs('0, '0);
      1: program_regs(MAX_MS, '0);
      2: program_regs(TIME_W'($urandom()), TIME_W'($urandom_range(1, 999)));
      3: program_regs(TIME_W'($urandom()), TIME_W'(60000));
      4: program_regs('0, MAX_MS);
      5: program_regs(TIME_W'($urandom()), REG_ALL_ONES);
      6: program_regs(REG_ALL_ONES, TIME_W'($urandom_range(1, 200000)));
      7: program_regs(TIME_W'($urandom()), '0);
      default: program_regs(TIME_W'($urandom()), TIME_W'($urandom()));
    endcase
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = CMD_TICK;
    cmd_bus.amount_ms  = '0;
    cmd_bus.pause_flag = 1'b0;
    res_bus.ready      = 1'b0;
    burst_left         = 0;
    quiet_cycles       = 0;
    rx_left            = 0;
    rx_pattern         = RX_OPEN;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // count-up, registers at reset values
    issue(CMD_TICK, AMT_W'(100), 1'b0);
    issue(CMD_START, '0, 1'b0);
    issue(CMD_TICK, AMT_POS_MAX, 1'b0);
    issue(CMD_TICK, AMT_NEG_MAX, 1'b0);
    issue(CMD_TICK, AMT_W'(61234), 1'b0);
    issue(CMD_PAUSE, '0, 1'b1);
    issue(CMD_TICK, AMT_W'(500), 1'b0);
    issue(CMD_END, '0, 1'b0);
    issue(CMD_ADD, AMT_POS_MAX, 1'b1);
    issue(CMD_PAUSE, '0, 1'b0);
    issue(CMD_START, '0, 1'b1);
    issue(CMD_START, '0, 1'b0);
    issue(CMD_RSVD6, AMT_POS_MAX, 1'b1);
    issue(CMD_RSVD7, AMT_NEG_MAX, 1'b0);
    issue(CMD_LOAD, '0, 1'b0);
    issue(CMD_END, '0, 1'b0);
    // start value above the ceiling
    program_regs(REG_ALL_ONES, '0);
    issue(CMD_LOAD, '0, 1'b0);
    // countdown that lands exactly on zero
    program_regs(MAX_MS, TIME_W'(1));
    issue(CMD_LOAD, '0, 1'b0);
    issue(CMD_START, '0, 1'b0);
    issue(CMD_TICK, AMT_W'(1), 1'b0);
    // limit above the ceiling
    program_regs('0, REG_ALL_ONES);
    issue(CMD_LOAD, '0, 1'b0);
    issue(CMD_START, '0, 1'b0);
    issue(CMD_TICK, AMT_NEG_MAX, 1'b0);
    issue(CMD_TICK, AMT_POS_MAX, 1'b0);
    issue(CMD_ADD, AMT_NEG_MAX, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      phase_regs(p);
      issue(CMD_LOAD, '0, 1'b0);
      issue(CMD_START, '0, 1'b0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain();
        random_cmd();
      end
    end

    drain();
    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
